[hw/rtl/vgrt_pkg.sv]
// Shared types and codes for the voxel grid ray traversal block.
// Used by voxel_grid_ray_traversal_top; no dependencies.
package vgrt_pkg;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic [5:0]         cell_z;
        logic [2:0]         cell_kind;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] start_dist;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         hit_x;
        logic [5:0]         hit_y;
        logic [5:0]         hit_z;
        logic [2:0]         hit_kind;
        logic signed [31:0] hit_dist;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_POS,
        ST_IDIV,
        ST_IDONE,
        ST_READ,
        ST_KIND,
        ST_QSET,
        ST_QDIV,
        ST_QDONE,
        ST_NEXT,
        ST_FIN
    } state_t;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_TRACE = 1'b1;

    localparam logic [1:0] STATUS_WRITE_DONE = 2'd0;
    localparam logic [1:0] STATUS_MISS       = 2'd1;
    localparam logic [1:0] STATUS_HIT        = 2'd2;

    localparam logic [2:0] CFG_CUBE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_X      = 3'd1;
    localparam logic [2:0] CFG_GRID_Y      = 3'd2;
    localparam logic [2:0] CFG_GRID_Z      = 3'd3;
    localparam logic [2:0] CFG_STEP_NUDGE  = 3'd4;
    localparam logic [2:0] CFG_PAR_THRESH  = 3'd5;

    localparam logic signed [65:0] FAR_START = 66'sd6553600000000;

endpackage

[hw/rtl/vgrt_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module vgrt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/voxel_grid_ray_traversal_top.sv]
// Voxel grid ray traversal: cell store, sequencer, shared multiplier and divider.
// Depends on vgrt_pkg and vgrt_ram.
//
//  channel  | signals                      | dir | word
//  ---------+------------------------------+-----+--------------------------
//  request  | req_valid, req_stall, req    | in  | req_t (write or trace)
//  result   | rsp_valid, rsp_stall, rsp    | out | rsp_t (one per request)
//  config   | cfg_we, cfg_index, cfg_data  | in  | register index and value
//
// A trace marches up to 4*GRID_DIM steps per ray; its divisions use the
// one-bit-per-cycle shared divider, IB = log2(GRID_DIM) bits per cell index.
// After reset a clearing pass empties the cell store; requests stall during
// it. A result waits in its register while the next request is taken.
module voxel_grid_ray_traversal_top
    import vgrt_pkg::*;
#(
    parameter int GRID_DIM = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int IB         = $clog2(GRID_DIM);
    localparam int AW         = 3 * IB;
    localparam int DEPTH      = 1 << AW;
    localparam int STEP_LIMIT = 4 * GRID_DIM;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam logic [8:0]    G9    = 9'(GRID_DIM);
    localparam logic [IB-1:0] IMASK = IB'(GRID_DIM - 1);

    state_t state_reg, state_next;

    logic [8:0]  cube_width_reg;
    logic [6:0]  grid_x_reg, grid_y_reg, grid_z_reg;
    logic [15:0] nudge_reg;
    logic [19:0] thresh_reg;

    logic signed [31:0] o_reg [3], o_next [3];
    logic signed [31:0] d_reg [3], d_next [3];
    logic [IB-1:0]      idx_reg [3], idx_next [3];
    logic [33:0]        n_reg [3], n_next [3];
    logic signed [31:0] t_reg, t_next;
    logic [1:0]         a_reg, a_next;
    logic [SW-1:0]      step_reg, step_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [35:0] p_reg, p_next;
    logic [32:0]        rem_reg, rem_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [32:0]        dvs_reg, dvs_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic signed [65:0] best_reg, best_next;
    logic [AW:0]        clr_reg, clr_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [2:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [2:0]      ram_rdata;

    logic [24:0]        wq;
    logic [8:0]         eff [3];
    logic signed [35:0] p_w;
    logic [34:0]        div_sh, div_diff;
    logic               div_ge;
    logic [32:0]        div_rem;
    logic [63:0]        div_dvd;
    logic [32:0]        d_abs;
    logic               usable;
    logic signed [35:0] num;
    logic [34:0]        num_abs;
    logic signed [65:0] q_w;
    logic signed [66:0] nt_w;
    logic               req_acc;
    logic               rsp_free;

    assign wq     = {cube_width_reg, 16'd0};
    assign eff[0] = (9'(grid_x_reg) > G9) ? G9 : 9'(grid_x_reg);
    assign eff[1] = (9'(grid_y_reg) > G9) ? G9 : 9'(grid_y_reg);
    assign eff[2] = (9'(grid_z_reg) > G9) ? G9 : 9'(grid_z_reg);

    assign p_w = 36'(o_reg[a_reg]) + 36'(prod_reg >>> 30);

    assign div_sh   = {1'b0, rem_reg, dvd_reg[63]};
    assign div_diff = div_sh - {2'b00, dvs_reg};
    assign div_ge   = !div_diff[34];
    assign div_rem  = div_ge ? div_diff[32:0] : div_sh[32:0];
    assign div_dvd  = {dvd_reg[62:0], div_ge};

    assign d_abs   = d_reg[a_reg][31] ? 33'd0 - 33'(d_reg[a_reg]) : 33'(d_reg[a_reg]);
    assign usable  = (d_reg[a_reg] != 32'sd0) && (d_abs >= 33'(thresh_reg));
    assign num     = $signed({2'b00, n_reg[a_reg]})
                     + (d_reg[a_reg][31] ? 36'sd0 : $signed(36'(wq)))
                     - 36'(o_reg[a_reg]);
    assign num_abs = num[35] ? 35'(-num) : 35'(num);
    assign q_w     = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
    assign nt_w    = 67'(best_reg) + 67'(nudge_reg);

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ram_raddr = {idx_reg[0], idx_reg[1], idx_reg[2]};

    vgrt_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == (AW + 1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = (req.req_type == REQ_WRITE) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_POS;
            end
            ST_POS:
            begin
                if (p_w < 0 || wq == 25'd0 || (p_w >>> IB) >= 36'(wq))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV:
            begin
                if (cnt_reg == 7'd1)
                begin
                    state_next = ST_IDONE;
                end
            end
            ST_IDONE:
            begin
                if (9'(dvd_reg[IB-1:0]) >= eff[a_reg])
                begin
                    state_next = ST_FIN;
                end
                else if (a_reg == 2'd2)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_READ:
            begin
                state_next = ST_KIND;
            end
            ST_KIND:
            begin
                state_next = (ram_rdata != 3'd0) ? ST_FIN : ST_QSET;
            end
            ST_QSET:
            begin
                if (usable)
                begin
                    state_next = ST_QDIV;
                end
                else if (a_reg == 2'd2)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_QDIV:
            begin
                if (cnt_reg == 7'd1)
                begin
                    state_next = ST_QDONE;
                end
            end
            ST_QDONE:
            begin
                state_next = (a_reg == 2'd2) ? ST_NEXT : ST_QSET;
            end
            ST_NEXT:
            begin
                state_next = (step_reg == SW'(STEP_LIMIT - 1)) ? ST_FIN : ST_MUL;
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_next[i]   = o_reg[i];
            d_next[i]   = d_reg[i];
            idx_next[i] = idx_reg[i];
            n_next[i]   = n_reg[i];
        end
        t_next         = t_reg;
        a_next         = a_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        best_next      = best_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = {IB'(req.cell_x), IB'(req.cell_y), IB'(req.cell_z)};
        ram_wdata      = req.cell_kind;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = 3'd0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                res_next = '0;
                if (req_acc)
                begin
                    if (req.req_type == REQ_WRITE)
                    begin
                        res_next.status = STATUS_WRITE_DONE;
                        ram_we = (9'(req.cell_x) < G9) && (9'(req.cell_y) < G9)
                                 && (9'(req.cell_z) < G9);
                    end
                    else
                    begin
                        o_next[0] = req.origin_x;
                        o_next[1] = req.origin_y;
                        o_next[2] = req.origin_z;
                        d_next[0] = req.dir_x;
                        d_next[1] = req.dir_y;
                        d_next[2] = req.dir_z;
                        t_next    = req.start_dist;
                        a_next    = 2'd0;
                        step_next = '0;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = d_reg[a_reg] * t_reg;
            end
            ST_POS:
            begin
                p_next   = p_w;
                rem_next = 33'(p_w >>> IB);
                dvd_next = {IB'(p_w), (64 - IB)'(0)};
                dvs_next = 33'(wq);
                cnt_next = 7'(IB);
                res_next.status   = STATUS_MISS;
                res_next.hit_dist = t_reg;
            end
            ST_IDIV, ST_QDIV:
            begin
                rem_next = div_rem;
                dvd_next = div_dvd;
                cnt_next = cnt_reg - 1'b1;
            end
            ST_IDONE:
            begin
                idx_next[a_reg] = dvd_reg[IB-1:0] & IMASK;
                n_next[a_reg]   = 34'(p_reg - $signed({3'b000, rem_reg}));
                a_next          = a_reg + 1'b1;
                if (a_reg == 2'd2)
                begin
                    a_next = 2'd0;
                end
            end
            ST_KIND:
            begin
                best_next = FAR_START;
                a_next    = 2'd0;
                res_next.status   = STATUS_HIT;
                res_next.hit_x    = 6'(idx_reg[0]);
                res_next.hit_y    = 6'(idx_reg[1]);
                res_next.hit_z    = 6'(idx_reg[2]);
                res_next.hit_kind = ram_rdata;
                res_next.hit_dist = t_reg;
            end
            ST_QSET:
            begin
                rem_next = '0;
                dvd_next = 64'({num_abs, 30'd0});
                dvs_next = d_abs;
                cnt_next = 7'd64;
                neg_next = num[35] ^ d_reg[a_reg][31];
                if (!usable && a_reg != 2'd2)
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            ST_QDONE:
            begin
                if (q_w < best_reg)
                begin
                    best_next = q_w;
                end
                if (a_reg != 2'd2)
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            ST_NEXT:
            begin
                if (nt_w > 67'sd2147483647)
                begin
                    t_next = 32'sh7FFFFFFF;
                end
                else if (nt_w < -67'sd2147483648)
                begin
                    t_next = 32'sh80000000;
                end
                else
                begin
                    t_next = 32'(nt_w);
                end
                step_next = step_reg + 1'b1;
                a_next    = 2'd0;
                res_next  = '0;
                res_next.status   = STATUS_MISS;
                res_next.hit_dist = t_next;
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            cube_width_reg <= 9'd50;
            grid_x_reg     <= 7'd50;
            grid_y_reg     <= 7'd50;
            grid_z_reg     <= 7'd50;
            nudge_reg      <= 16'd7;
            thresh_reg     <= 20'd1074;
            a_reg          <= 2'd0;
            step_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            a_reg         <= a_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CUBE_WIDTH: cube_width_reg <= cfg_data[8:0];
                    CFG_GRID_X:     grid_x_reg     <= cfg_data[6:0];
                    CFG_GRID_Y:     grid_y_reg     <= cfg_data[6:0];
                    CFG_GRID_Z:     grid_z_reg     <= cfg_data[6:0];
                    CFG_STEP_NUDGE: nudge_reg      <= cfg_data[15:0];
                    CFG_PAR_THRESH: thresh_reg     <= cfg_data;
                    default:        nudge_reg      <= nudge_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_reg[i]   <= o_next[i];
            d_reg[i]   <= d_next[i];
            idx_reg[i] <= idx_next[i];
            n_reg[i]   <= n_next[i];
        end
        t_reg    <= t_next;
        prod_reg <= prod_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        best_reg <= best_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule

[bench/tb_voxel_grid_ray_traversal_top.sv]
// Testbench for voxel_grid_ray_traversal_top: a directed table, then random phases of
// cell writes and ray traces; each result is checked against a fixed expected word or a local ray-march predictor.
// Depends on vgrt_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_voxel_grid_ray_traversal_top;
    import vgrt_pkg::*;

    localparam int    DIM        = 64;
    localparam int    MARCH_MAX  = 4 * DIM;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint FAR_T     = 64'sd6553600000000;
    localparam int    CYCLE_CAP  = 40_000_000;
    localparam int    UNIT       = 65536;
    localparam int    REQ_W      = $bits(req_t);

    typedef struct {
        bit          is_cfg;
        int unsigned cw, gx, gy, gz, nd, th;
        req_t        word;
        bit          fixed;
        rsp_t        exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    bit [2:0]    cells [0:DIM*DIM*DIM-1];
    int unsigned cube_w, gsz[3], nudge, thr;
    rsp_t        pending_rsp[$];
    row_t        plan[$];
    int          fails;
    int          cycles;
    int          hold_left;
    bit          quiet;

    voxel_grid_ray_traversal_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_size(int unsigned s);
        return (s > DIM) ? DIM : s;
    endfunction

    function automatic rsp_t march_ray(req_t w);
        longint      o[3], d[3], lim[3];
        longint      t, wq, p, best, n, q, nt, ad;
        int unsigned ix[3];
        bit          outside;
        bit [2:0]    k;
        rsp_t        r;
        r = '0;
        r.status = STATUS_MISS;
        o[0] = w.origin_x; o[1] = w.origin_y; o[2] = w.origin_z;
        d[0] = w.dir_x;    d[1] = w.dir_y;    d[2] = w.dir_z;
        wq = longint'(cube_w) * UNIT;
        for (int a = 0; a < 3; a++)
            lim[a] = clamp_size(gsz[a]) * wq;
        t = w.start_dist;
        for (int s = 0; s < MARCH_MAX; s++)
        begin
            best = FAR_T;
            outside = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                p = o[a] + ((d[a] * t) >>> 30);
                if (p < 0 || p >= lim[a] || wq == 0)
                begin
                    outside = 1'b1;
                    break;
                end
                ix[a] = int'(p / wq) & (DIM - 1);
            end
            if (outside)
                break;
            k = cells[(ix[0] * DIM + ix[1]) * DIM + ix[2]];
            if (k != 0)
            begin
                r.status   = STATUS_HIT;
                r.hit_x    = ix[0][5:0];
                r.hit_y    = ix[1][5:0];
                r.hit_z    = ix[2][5:0];
                r.hit_kind = k;
                break;
            end
            for (int a = 0; a < 3; a++)
            begin
                ad = (d[a] < 0) ? -d[a] : d[a];
                if (d[a] == 0 || ad < longint'(thr))
                    continue;
                n = longint'(ix[a]) * wq;
                if (d[a] > 0)
                    n += wq;
                q = ((n - o[a]) * ONE_Q30) / d[a];
                if (q < best)
                    best = q;
            end
            nt = best + longint'(nudge);
            if (nt > 64'sd2147483647)
                nt = 64'sd2147483647;
            if (nt < -64'sd2147483648)
                nt = -64'sd2147483648;
            t = nt;
        end
        r.hit_dist = t[31:0];
        return r;
    endfunction

    function automatic rsp_t apply_word(req_t w);
        rsp_t r;
        r = '0;
        if (w.req_type == REQ_WRITE)
        begin
            cells[(int'(w.cell_x) * DIM + int'(w.cell_y)) * DIM + int'(w.cell_z)] = w.cell_kind;
            r.status = STATUS_WRITE_DONE;
        end
        else
            r = march_ray(w);
        return r;
    endfunction

    task automatic send_word(req_t w, bit fixed, rsp_t exp);
        int   gap;
        rsp_t pred;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        pred = apply_word(w);
        pending_rsp.push_back(fixed ? exp : pred);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_word(logic [2:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[19:0];
        @(posedge clk);
    endtask

    task automatic apply_cfg(int unsigned cw, gx, gy, gz, nd, th);
        drain();
        cfg_word(CFG_CUBE_WIDTH, cw);
        cfg_word(CFG_GRID_X, gx);
        cfg_word(CFG_GRID_Y, gy);
        cfg_word(CFG_GRID_Z, gz);
        cfg_word(CFG_STEP_NUDGE, nd);
        cfg_word(CFG_PAR_THRESH, th);
        cfg_we <= 1'b0;
        cube_w = cw & 32'h1FF;
        gsz[0] = gx & 32'h7F;
        gsz[1] = gy & 32'h7F;
        gsz[2] = gz & 32'h7F;
        nudge  = nd & 32'hFFFF;
        thr    = th & 32'hFFFFF;
    endtask

    function automatic req_t mk_write(int x, int y, int z, int k);
        req_t w;
        w = '0;
        w.req_type  = REQ_WRITE;
        w.cell_x    = 6'(x);
        w.cell_y    = 6'(y);
        w.cell_z    = 6'(z);
        w.cell_kind = 3'(k);
        return w;
    endfunction

    function automatic req_t mk_trace(int ox, int oy, int oz, int dx, int dy, int dz, int t0);
        req_t w;
        w = '0;
        w.req_type   = REQ_TRACE;
        w.origin_x   = ox;
        w.origin_y   = oy;
        w.origin_z   = oz;
        w.dir_x      = dx;
        w.dir_y      = dy;
        w.dir_z      = dz;
        w.start_dist = t0;
        return w;
    endfunction

    function automatic rsp_t mk_rsp(logic [1:0] st, int x, int y, int z, int k, int t_end);
        rsp_t r;
        r.status   = st;
        r.hit_x    = 6'(x);
        r.hit_y    = 6'(y);
        r.hit_z    = 6'(z);
        r.hit_kind = 3'(k);
        r.hit_dist = t_end;
        return r;
    endfunction

    function automatic void add_req(req_t w);
        row_t r;
        r = '{default: 0};
        r.word = w;
        plan.push_back(r);
    endfunction

    function automatic void add_fixed(req_t w, rsp_t e);
        row_t r;
        r = '{default: 0};
        r.word  = w;
        r.fixed = 1'b1;
        r.exp   = e;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(int unsigned cw, gx, gy, gz, nd, th);
        row_t r;
        r = '{default: 0};
        r.is_cfg = 1'b1;
        r.cw = cw; r.gx = gx; r.gy = gy; r.gz = gz; r.nd = nd; r.th = th;
        plan.push_back(r);
    endfunction

    function automatic void build_plan();
        rsp_t wdone;
        wdone = mk_rsp(STATUS_WRITE_DONE, 0, 0, 0, 0, 0);
        add_req(mk_trace(25*UNIT, 25*UNIT, 25*UNIT, 1 << 30, 0, 0, 0));
        add_fixed(mk_write(0, 0, 0, 7), wdone);
        add_fixed(mk_trace(UNIT, UNIT, UNIT, 0, 0, 0, 0), mk_rsp(STATUS_HIT, 0, 0, 0, 7, 0));
        add_fixed(mk_write(63, 63, 63, 1), wdone);
        add_fixed(mk_trace(32'h80000000, 0, 0, 0, 0, 0, 32'h7FFFFFFF),
                  mk_rsp(STATUS_MISS, 0, 0, 0, 0, 32'h7FFFFFFF));
        add_fixed(mk_trace(1000*UNIT, 1000*UNIT, 1000*UNIT, 0, 0, 0, 0),
                  mk_rsp(STATUS_MISS, 0, 0, 0, 0, 32'h7FFFFFFF));
        add_req(mk_trace(1000*UNIT, 1000*UNIT, 1000*UNIT, 1073, -1073, 1, -5));
        add_req(mk_trace(60*UNIT, 60*UNIT, 60*UNIT, 32'h80000000, 32'h7FFFFFFF,
                         32'hC0000000, 0));
        add_fixed(mk_write(5, 0, 0, 3), wdone);
        add_fixed(mk_write(0, 0, 0, 0), wdone);
        add_req(mk_trace(10*UNIT, 10*UNIT, 10*UNIT, 1 << 30, 0, 0, 0));
        add_req(mk_trace(100*UNIT, 100*UNIT, 100*UNIT, 1 << 30, 1 << 30, 1 << 30, -50*UNIT));
        add_cfg(0, 50, 50, 50, 7, 1074);
        add_fixed(mk_trace(UNIT, UNIT, UNIT, 1 << 30, 1 << 30, 1 << 30, 12345),
                  mk_rsp(STATUS_MISS, 0, 0, 0, 0, 12345));
        add_cfg(511, 64, 64, 64, 65535, 0);
        add_req(mk_trace(100*UNIT, 100*UNIT, 100*UNIT, 1 << 30, 0, 0, 0));
        add_fixed(mk_write(63, 63, 63, 6), wdone);
        add_fixed(mk_trace(32300*UNIT, 32300*UNIT, 32300*UNIT, 0, 0, 0, 0),
                  mk_rsp(STATUS_HIT, 63, 63, 63, 6, 0));
        add_cfg(1, 0, 1, 1, 1, 1048575);
        add_fixed(mk_trace(0, 0, 0, 1 << 30, 0, 0, 777), mk_rsp(STATUS_MISS, 0, 0, 0, 0, 777));
        add_cfg(1, 127, 1, 1, 1, 1048575);
        add_req(mk_trace(UNIT/2, UNIT/2, UNIT/2, 1 << 30, 1 << 29, 0, 0));
    endfunction

    function automatic req_t rand_word();
        req_t        w;
        longint      lim;
        int unsigned sel;
        w = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom}));
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            w.req_type = REQ_WRITE;
            if (sel < 3)
            begin
                w.cell_x = 6'($urandom_range(0, clamp_size(gsz[0]) - 1));
                w.cell_y = 6'($urandom_range(0, clamp_size(gsz[1]) - 1));
                w.cell_z = 6'($urandom_range(0, clamp_size(gsz[2]) - 1));
            end
        end
        else
        begin
            w.req_type = REQ_TRACE;
            if (sel < 9)
            begin
                lim = clamp_size(gsz[0]) * cube_w * UNIT;
                w.origin_x = $urandom_range(0, lim - 1);
                lim = clamp_size(gsz[1]) * cube_w * UNIT;
                w.origin_y = $urandom_range(0, lim - 1);
                lim = clamp_size(gsz[2]) * cube_w * UNIT;
                w.origin_z = $urandom_range(0, lim - 1);
                if ($urandom_range(0, 3) == 0)
                    w.dir_y = $urandom_range(0, 2047) - 1024;
                if ($urandom_range(0, 4) == 0)
                    w.dir_z = 0;
                w.start_dist = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4*UNIT);
            end
        end
        return w;
    endfunction

    task automatic check_word(rsp_t got, rsp_t exp);
        if (got.status !== exp.status)
        begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            fails++;
        end
        if (got.hit_x !== exp.hit_x)
        begin
            $error("hit_x expected %0d actual %0d", exp.hit_x, got.hit_x);
            fails++;
        end
        if (got.hit_y !== exp.hit_y)
        begin
            $error("hit_y expected %0d actual %0d", exp.hit_y, got.hit_y);
            fails++;
        end
        if (got.hit_z !== exp.hit_z)
        begin
            $error("hit_z expected %0d actual %0d", exp.hit_z, got.hit_z);
            fails++;
        end
        if (got.hit_kind !== exp.hit_kind)
        begin
            $error("hit_kind expected %0d actual %0d", exp.hit_kind, got.hit_kind);
            fails++;
        end
        if (got.hit_dist !== exp.hit_dist)
        begin
            $error("hit_dist expected %0d actual %0d", exp.hit_dist, got.hit_dist);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        bit next_stall;
        next_stall = 1'b0;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result word with nothing expected");
                fails++;
            end
            else
                check_word(rsp, pending_rsp.pop_front());
            hold_left = quiet ? 0 : $urandom_range(0, 9);
        end
        if (hold_left > 0)
        begin
            next_stall = 1'b1;
            hold_left--;
        end
        rsp_stall <= next_stall;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        fails     = 0;
        cycles    = 0;
        hold_left = 0;
        quiet     = 1'b0;
        cube_w = 50; gsz[0] = 50; gsz[1] = 50; gsz[2] = 50; nudge = 7; thr = 1074;
        build_plan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                apply_cfg(plan[i].cw, plan[i].gx, plan[i].gy, plan[i].gz, plan[i].nd,
                          plan[i].th);
            else
                send_word(plan[i].word, plan[i].fixed, plan[i].exp);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                apply_cfg($urandom_range(1, 511), $urandom_range(65, 127), 1, 1,
                          $urandom_range(1, 65535), $urandom_range(0, 1048575));
            else
                apply_cfg($urandom_range(1, 511), $urandom_range(1, 6), $urandom_range(1, 6),
                          $urandom_range(1, 6), $urandom_range(1, 65535),
                          $urandom_range(0, 4096));
            quiet = (ph % 3 == 1);
            for (int k = 0; k < 16; k++)
                send_word(rand_word(), 1'b0, '0);
        end

        drain();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
